// ----- src/spas_pkg.sv -----
// Shared types and constants for the service probe and announce sequencer.
package spas_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int COUNT_W     = 4;
   localparam int FIFO_AW     = 3;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_REGISTER   = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_RESTART    = 3'd3,
      OP_START      = 3'd4,
      OP_STOP       = 3'd5,
      OP_CONFLICT   = 3'd6,
      OP_TIE_LOST   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MODE_INIT       = 2'd0,
      MODE_PROBING    = 2'd1,
      MODE_ANNOUNCING = 2'd2,
      MODE_IDLE       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_PROBE    = 2'd0,
      ACT_ANNOUNCE = 2'd1,
      ACT_GOODBYE  = 2'd2,
      ACT_RENAME   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_ANNOUNCE_COUNT  = 3'd0,
      CSR_PROBE_COUNT     = 3'd1,
      CSR_PROBE_INTERVAL  = 3'd2,
      CSR_FIRST_ANNOUNCE  = 3'd3,
      CSR_CONFLICT_DELAY  = 3'd4,
      CSR_DEFER_DELAY     = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [3:0]  announce_count;
      logic [3:0]  probe_count;
      logic [15:0] probe_interval;
      logic [15:0] first_announce_interval;
      logic [15:0] conflict_delay;
      logic [15:0] defer_delay;
   } cfg_type;

   // Tick context travelling along the row of slot cells.
   typedef struct packed {
      logic               valid;
      logic [31:0]        now;
      logic [15:0]        rnd;
      logic               host;
      logic [2:0]         slot;
      logic [COUNT_W-1:0] count;
   } tok_type;

   typedef struct packed {
      logic all_init;
      logic set_valid;
      logic clr_valid;
      logic set_conflict;
      logic set_tie;
   } cell_cmd_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] slot;
      action_type action;
      mode_type   mode;
   } res_type;

   typedef struct packed {
      logic [2:0] slot;
      action_type action;
      mode_type   mode;
      logic       last;
   } out_type;

endpackage

// ----- src/spas_cell.sv -----
// One service slot: holds its state and runs the probe and announce rules when the tick passes.
module spas_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spas_pkg::cfg_type     cfg,
   input  logic                  running,
   input  spas_pkg::cell_cmd_type cmd,
   input  spas_pkg::tok_type     tok_i,
   output spas_pkg::tok_type     tok_o,
   output spas_pkg::res_type     res,
   output logic                  valid_o,
   output spas_pkg::mode_type    mode_o
);
   import spas_pkg::*;

   logic        valid_ff, valid_in;
   mode_type    mode_ff, mode_in;
   logic [31:0] send_ff, send_in;
   logic [31:0] wait_ff, wait_in;
   logic [3:0]  retry_ff, retry_in;
   logic        conflict_ff, conflict_in;
   logic        tie_ff, tie_in;
   tok_type     tok_ff, tok_in;

   logic [31:0] deadline;
   logic [31:0] diff;
   logic        due;
   logic [3:0]  retry_inc;
   logic        want_emit;
   action_type  act;
   logic        emit_ok;

   assign deadline  = send_ff + wait_ff;
   assign diff      = tok_i.now - deadline;
   assign due       = !diff[31];
   assign retry_inc = retry_ff + 4'd1;
   assign emit_ok   = tok_i.count < COUNT_W'(MAX_RESULTS);

   always_comb begin
      valid_in    = valid_ff;
      mode_in     = mode_ff;
      send_in     = send_ff;
      wait_in     = wait_ff;
      retry_in    = retry_ff;
      conflict_in = conflict_ff;
      tie_in      = tie_ff;
      want_emit   = 1'b0;
      act         = ACT_PROBE;

      if (tok_i.valid && valid_ff) begin
         case (mode_ff)
            MODE_INIT: begin
               if (running && tok_i.host) begin
                  mode_in  = MODE_PROBING;
                  send_in  = tok_i.now;
                  wait_in  = {16'd0, tok_i.rnd};
                  retry_in = 4'd0;
               end
            end
            MODE_PROBING: begin
               if (conflict_ff && retry_ff != 4'd0) begin
                  send_in   = tok_i.now;
                  wait_in   = {16'd0, cfg.conflict_delay};
                  retry_in  = 4'd0;
                  want_emit = 1'b1;
                  act       = ACT_RENAME;
               end else if (tie_ff && retry_ff != 4'd0) begin
                  send_in  = tok_i.now;
                  wait_in  = {16'd0, cfg.defer_delay};
                  retry_in = 4'd0;
               end else if (due) begin
                  if (retry_ff < cfg.probe_count) begin
                     // The first probe of a round starts with clean flags.
                     if (retry_ff == 4'd0) begin
                        conflict_in = 1'b0;
                        tie_in      = 1'b0;
                     end
                     send_in   = tok_i.now;
                     wait_in   = {16'd0, cfg.probe_interval};
                     retry_in  = retry_inc;
                     want_emit = 1'b1;
                     act       = ACT_PROBE;
                  end else begin
                     mode_in  = (cfg.announce_count != 4'd0) ? MODE_ANNOUNCING : MODE_IDLE;
                     send_in  = tok_i.now;
                     wait_in  = 32'd0;
                     retry_in = 4'd0;
                  end
               end
            end
            MODE_ANNOUNCING: begin
               if (conflict_ff) begin
                  mode_in  = MODE_PROBING;
                  send_in  = tok_i.now;
                  wait_in  = 32'd0;
                  retry_in = 4'd0;
               end else if (due) begin
                  send_in   = tok_i.now;
                  want_emit = 1'b1;
                  act       = ACT_ANNOUNCE;
                  if (retry_inc >= cfg.announce_count) begin
                     mode_in  = MODE_IDLE;
                     wait_in  = 32'd0;
                     retry_in = 4'd0;
                  end else begin
                     retry_in = retry_inc;
                     wait_in  = (retry_inc == 4'd1) ? {16'd0, cfg.first_announce_interval}
                                                    : {wait_ff[30:0], 1'b0};
                  end
               end
            end
            default: begin
               if (conflict_ff) begin
                  mode_in  = MODE_PROBING;
                  send_in  = tok_i.now;
                  wait_in  = 32'd0;
                  retry_in = 4'd0;
               end
            end
         endcase
      end

      if (cmd.all_init) begin
         mode_in = MODE_INIT;
      end
      if (cmd.set_valid) begin
         valid_in = 1'b1;
      end else if (cmd.clr_valid) begin
         valid_in = 1'b0;
      end
      if (cmd.set_conflict) begin
         conflict_in = 1'b1;
      end
      if (cmd.set_tie) begin
         tie_in = 1'b1;
      end
   end

   always_comb begin
      res = '0;
      if (want_emit && emit_ok) begin
         res.valid  = 1'b1;
         res.slot   = tok_i.slot;
         res.action = act;
         res.mode   = mode_in;
      end
      tok_in       = tok_i;
      tok_in.slot  = tok_i.slot + 3'd1;
      tok_in.count = tok_i.count + COUNT_W'(res.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         mode_ff     <= MODE_INIT;
         send_ff     <= '0;
         wait_ff     <= '0;
         retry_ff    <= '0;
         conflict_ff <= 1'b0;
         tie_ff      <= 1'b0;
         tok_ff      <= '0;
      end else begin
         valid_ff    <= valid_in;
         mode_ff     <= mode_in;
         send_ff     <= send_in;
         wait_ff     <= wait_in;
         retry_ff    <= retry_in;
         conflict_ff <= conflict_in;
         tie_ff      <= tie_in;
         tok_ff      <= tok_in;
      end
   end

   assign tok_o   = tok_ff;
   assign valid_o = valid_ff;
   assign mode_o  = mode_ff;

   // A slot only changes on a command or while the tick is at this cell.
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      (!tok_i.valid && cmd == '0) |=> $stable(retry_ff) && $stable(send_ff))
      else $error("slot state changed without tick or command");

endmodule

// ----- src/spas_collect.sv -----
// Result collector: holds back the newest result to mark the last one, then queues for output.
module spas_collect (
   input  logic               clock,
   input  logic               reset,
   input  spas_pkg::res_type  cell_res,
   input  logic               walk_end,
   input  spas_pkg::res_type  direct_res,
   output spas_pkg::out_type  head,
   output logic               head_valid,
   input  logic               head_take,
   output logic               idle
);
   import spas_pkg::*;

   localparam int DEPTH = MAX_RESULTS;

   out_type            fifo_ff [DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in;
   logic [FIFO_AW-1:0] rd_ff, rd_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   res_type            pend_ff, pend_in;

   logic    push;
   out_type push_data;
   logic    pop;

   always_comb begin
      push      = 1'b0;
      push_data = '0;
      pend_in   = pend_ff;
      if (direct_res.valid) begin
         push      = 1'b1;
         push_data = {direct_res.slot, direct_res.action, direct_res.mode, 1'b1};
      end else if (cell_res.valid) begin
         // A newer result arrived, so the held one cannot be the last.
         push      = pend_ff.valid;
         push_data = {pend_ff.slot, pend_ff.action, pend_ff.mode, 1'b0};
         pend_in   = cell_res;
      end else if (walk_end) begin
         push      = pend_ff.valid;
         push_data = {pend_ff.slot, pend_ff.action, pend_ff.mode, 1'b1};
         pend_in   = '0;
      end
      pop    = head_take && (cnt_ff != '0);
      wr_in  = wr_ff + FIFO_AW'(push);
      rd_in  = rd_ff + FIFO_AW'(pop);
      cnt_in = cnt_ff + COUNT_W'(push) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
         pend_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= push_data;
      end
   end

   assign head       = fifo_ff[rd_ff];
   assign head_valid = cnt_ff != '0;
   assign idle       = (cnt_ff == '0) && !pend_ff.valid;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != COUNT_W'(DEPTH)) || pop)
      else $error("result queue overflow");

   a_end_alone: assert property (@(posedge clock) disable iff (reset)
      !(cell_res.valid && walk_end))
      else $error("cell result coincides with end of walk");

endmodule

// ----- src/service_probe_announce_sequencer.sv -----
// Top level of the service probe and announce sequencer: control, settings and the slot cell row.
//
//   channel  ports        payload
//   request  req_t*       tuser: op; tdata: slot, now, rand_delay, host_ready
//   result   rsp_t*       tuser: action; tdata: slot_out, mode_after; tlast: last
//   config   csr_*        six registers, write only
//
// A tick request enters the first cell and moves one cell per cycle, passing the whole
// row before its results are all queued; other requests are handled on acceptance.
// A new request is taken only once every result of the previous one has been read.
// Reset clears all slot state and loads the register defaults; a stalled result
// side holds the row idle but never loses a result.
module service_probe_announce_sequencer #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // slot[2:0], now[34:3], rand_delay[50:35], host_ready[51]
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // slot_out[2:0], mode_after[4:3]
   output logic [1:0]  rsp_tuser,  // action
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import spas_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    running_ff, running_in;
   logic    busy_ff, busy_in;
   tok_type head_ff, head_in;

   op_type      op;
   logic [2:0]  req_slot;
   logic        accept;

   tok_type      tok_chain [NUM_SLOTS+1];
   cell_cmd_type cmd       [NUM_SLOTS];
   res_type      res       [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_vec;
   mode_type     mode_vec  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] hit;
   logic [NUM_SLOTS:0]   tok_vld;

   logic     in_range;
   logic     was_valid;
   mode_type sel_mode;
   res_type  res_any;
   res_type  direct_res;
   out_type  head;
   logic     head_valid;
   logic     coll_idle;
   logic     walk_end;

   assign op       = op_type'(req_tuser);
   assign req_slot = req_tdata[2:0];
   assign accept   = req_tvalid && req_tready;
   assign walk_end = tok_chain[NUM_SLOTS].valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_ANNOUNCE_COUNT: cfg_in.announce_count          = csr_wdata[3:0];
            CSR_PROBE_COUNT:    cfg_in.probe_count             = csr_wdata[3:0];
            CSR_PROBE_INTERVAL: cfg_in.probe_interval          = csr_wdata;
            CSR_FIRST_ANNOUNCE: cfg_in.first_announce_interval = csr_wdata;
            CSR_CONFLICT_DELAY: cfg_in.conflict_delay          = csr_wdata;
            CSR_DEFER_DELAY:    cfg_in.defer_delay             = csr_wdata;
            default:            cfg_in                         = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_range  = |hit;
      was_valid = |(hit & valid_vec);
      sel_mode  = MODE_INIT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (hit[i]) begin
            sel_mode = mode_vec[i];
         end
      end
   end

   always_comb begin
      running_in = running_ff;
      busy_in    = busy_ff;
      head_in    = '0;
      direct_res = '0;
      if (walk_end) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         case (op)
            OP_TICK: begin
               busy_in       = 1'b1;
               head_in.valid = 1'b1;
               head_in.now   = req_tdata[34:3];
               head_in.rnd   = req_tdata[50:35];
               head_in.host  = req_tdata[51];
            end
            OP_REGISTER, OP_UNREGISTER: begin
               // The goodbye of a register request reports the slot already reset to init.
               direct_res.valid  = was_valid;
               direct_res.slot   = req_slot;
               direct_res.action = ACT_GOODBYE;
               direct_res.mode   = (op == OP_REGISTER) ? MODE_INIT : sel_mode;
            end
            OP_START: running_in = 1'b1;
            OP_STOP:  running_in = 1'b0;
            default:  running_in = running_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.announce_count          <= 4'd2;
         cfg_ff.probe_count             <= 4'd3;
         cfg_ff.probe_interval          <= 16'd250;
         cfg_ff.first_announce_interval <= 16'd1000;
         cfg_ff.conflict_delay          <= 16'd1000;
         cfg_ff.defer_delay             <= 16'd1000;
         running_ff                     <= 1'b0;
         busy_ff                        <= 1'b0;
         head_ff                        <= '0;
      end else begin
         cfg_ff     <= cfg_in;
         running_ff <= running_in;
         busy_ff    <= busy_in;
         head_ff    <= head_in;
      end
   end

   assign tok_chain[0] = head_ff;
   assign tok_vld[0]   = head_ff.valid;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      assign hit[i] = ({29'd0, req_slot} == 32'(i));

      always_comb begin
         cmd[i].all_init     = accept && (((op == OP_REGISTER) && in_range) ||
                               (op == OP_RESTART) || (op == OP_START) || (op == OP_STOP));
         cmd[i].set_valid    = accept && (op == OP_REGISTER) && hit[i];
         cmd[i].clr_valid    = accept && (op == OP_UNREGISTER) && hit[i];
         cmd[i].set_conflict = accept && (op == OP_CONFLICT) && hit[i];
         cmd[i].set_tie      = accept && (op == OP_TIE_LOST) && hit[i];
      end

      spas_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .running (running_ff),
         .cmd     (cmd[i]),
         .tok_i   (tok_chain[i]),
         .tok_o   (tok_chain[i+1]),
         .res     (res[i]),
         .valid_o (valid_vec[i]),
         .mode_o  (mode_vec[i])
      );

      assign tok_vld[i+1] = tok_chain[i+1].valid;
   end

   // Only the cell holding the tick can drive a result, so an OR picks it.
   always_comb begin
      res_any = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         res_any = res_any | res[i];
      end
   end

   spas_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .cell_res   (res_any),
      .walk_end   (walk_end),
      .direct_res (direct_res),
      .head       (head),
      .head_valid (head_valid),
      .head_take  (rsp_tready),
      .idle       (coll_idle)
   );

   assign req_tready = !busy_ff && coll_idle;
   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {3'd0, head.mode, head.slot};
   assign rsp_tuser  = head.action;
   assign rsp_tlast  = head.last;

   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vld))
      else $error("more than one tick in the cell row");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (|tok_vld) |-> busy_ff)
      else $error("tick in flight while not busy");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the service probe and announce sequencer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spas_pkg::*;

   localparam int NUM_SLOTS    = 8;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct {
      op_type      op;
      logic [2:0]  slot;
      logic [31:0] now;
      logic [15:0] rnd;
      logic        host;
   } svc_request_t;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   service_probe_announce_sequencer #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Shadow copy of the slot table and the settings.
   cfg_type     cfg;
   logic        is_running;
   logic        svc_valid    [NUM_SLOTS];
   mode_type    svc_mode     [NUM_SLOTS];
   logic [31:0] svc_sent     [NUM_SLOTS];
   logic [31:0] svc_delay    [NUM_SLOTS];
   logic [3:0]  svc_retries  [NUM_SLOTS];
   logic        svc_conflict [NUM_SLOTS];
   logic        svc_tie_lost [NUM_SLOTS];

   out_type      step_actions[$];
   out_type      expected_actions[$];
   svc_request_t pending_requests[$];
   svc_request_t req_item;

   int  queued_count = 0;
   int  taken_count  = 0;
   int  error_count  = 0;
   int  cycle_count  = 0;
   int  tx_gap       = 0;
   int  tx_burst     = 0;
   int  rx_stall     = 0;
   int  rx_burst     = 0;
   int  hold_left    = 0;
   bit  hold_armed   = 1'b0;
   bit  hold_done    = 1'b0;
   bit  req_fire;
   logic [31:0] clock_ms = 32'd0;
   logic [31:0] span     = 32'd1000;

   function automatic int pick_gap(ref int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic reset_model();
      cfg.announce_count          = 4'd2;
      cfg.probe_count             = 4'd3;
      cfg.probe_interval          = 16'd250;
      cfg.first_announce_interval = 16'd1000;
      cfg.conflict_delay          = 16'd1000;
      cfg.defer_delay             = 16'd1000;
      is_running = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         svc_valid[i]    = 1'b0;
         svc_mode[i]     = MODE_INIT;
         svc_sent[i]     = '0;
         svc_delay[i]    = '0;
         svc_retries[i]  = '0;
         svc_conflict[i] = 1'b0;
         svc_tie_lost[i] = 1'b0;
      end
   endtask

   task automatic log_action(int s, action_type act);
      out_type entry;
      if (step_actions.size() < MAX_RESULTS) begin
         entry.slot   = s[2:0];
         entry.action = act;
         entry.mode   = svc_mode[s];
         entry.last   = 1'b0;
         step_actions.push_back(entry);
      end
   endtask

   task automatic enter_mode(int s, mode_type m, logic [31:0] t, logic [31:0] d);
      svc_mode[s]    = m;
      svc_sent[s]    = t;
      svc_delay[s]   = d;
      svc_retries[s] = '0;
   endtask

   task automatic all_to_init();
      for (int i = 0; i < NUM_SLOTS; i++) svc_mode[i] = MODE_INIT;
   endtask

   // Wrapping comparison: the slot is due when bit 31 of the distance is clear.
   function automatic logic slot_due(int s, logic [31:0] t);
      logic [31:0] lag;
      lag = t - (svc_sent[s] + svc_delay[s]);
      return !lag[31];
   endfunction

   task automatic advance_slot(int s, svc_request_t rq);
      case (svc_mode[s])
         MODE_INIT: begin
            if (is_running && rq.host) enter_mode(s, MODE_PROBING, rq.now, {16'd0, rq.rnd});
         end
         MODE_PROBING: begin
            if (svc_conflict[s] && svc_retries[s] != 0) begin
               enter_mode(s, MODE_PROBING, rq.now, {16'd0, cfg.conflict_delay});
               log_action(s, ACT_RENAME);
            end else if (svc_tie_lost[s] && svc_retries[s] != 0) begin
               enter_mode(s, MODE_PROBING, rq.now, {16'd0, cfg.defer_delay});
            end else if (slot_due(s, rq.now)) begin
               if (svc_retries[s] < cfg.probe_count) begin
                  if (svc_retries[s] == 0) begin
                     svc_conflict[s] = 1'b0;
                     svc_tie_lost[s] = 1'b0;
                  end
                  svc_sent[s]    = rq.now;
                  svc_delay[s]   = {16'd0, cfg.probe_interval};
                  svc_retries[s] = svc_retries[s] + 4'd1;
                  log_action(s, ACT_PROBE);
               end else if (cfg.announce_count != 0) begin
                  enter_mode(s, MODE_ANNOUNCING, rq.now, 32'd0);
               end else begin
                  enter_mode(s, MODE_IDLE, rq.now, 32'd0);
               end
            end
         end
         MODE_ANNOUNCING: begin
            if (svc_conflict[s]) begin
               enter_mode(s, MODE_PROBING, rq.now, 32'd0);
            end else if (slot_due(s, rq.now)) begin
               svc_sent[s]    = rq.now;
               svc_retries[s] = svc_retries[s] + 4'd1;
               if (svc_retries[s] == 4'd1) svc_delay[s] = {16'd0, cfg.first_announce_interval};
               else svc_delay[s] = svc_delay[s] << 1;
               if (svc_retries[s] >= cfg.announce_count) enter_mode(s, MODE_IDLE, rq.now, 32'd0);
               log_action(s, ACT_ANNOUNCE);
            end
         end
         default: begin
            if (svc_conflict[s]) enter_mode(s, MODE_PROBING, rq.now, 32'd0);
         end
      endcase
   endtask

   task automatic predict_actions(svc_request_t rq);
      int s;
      logic was_valid;
      s = int'(rq.slot);
      step_actions.delete();
      case (rq.op)
         OP_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (svc_valid[i]) advance_slot(i, rq);
         end
         OP_REGISTER: begin
            was_valid = svc_valid[s];
            svc_valid[s] = 1'b1;
            all_to_init();
            if (was_valid) log_action(s, ACT_GOODBYE);
         end
         OP_UNREGISTER: begin
            if (svc_valid[s]) log_action(s, ACT_GOODBYE);
            svc_valid[s] = 1'b0;
         end
         OP_RESTART: all_to_init();
         OP_START: begin
            is_running = 1'b1;
            all_to_init();
         end
         OP_STOP: begin
            is_running = 1'b0;
            all_to_init();
         end
         OP_CONFLICT: svc_conflict[s] = 1'b1;
         default: svc_tie_lost[s] = 1'b1;
      endcase
      if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
      foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
   endtask

   task automatic queue_request(op_type op, logic [2:0] slot, logic [31:0] now,
                                logic [15:0] rnd, logic host);
      svc_request_t rq;
      rq.op   = op;
      rq.slot = slot;
      rq.now  = now;
      rq.rnd  = rnd;
      rq.host = host;
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   task automatic flag_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            predict_actions(req_item);
            taken_count++;
         end
         if (!req_tvalid || req_fire) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_item = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'd0, req_item.host, req_item.rnd, req_item.now, req_item.slot};
               req_tuser  <= req_item.op;
               tx_gap = pick_gap(tx_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side backpressure, with one long hold so the block stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done && rsp_tvalid) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rx_stall = pick_gap(rx_burst);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_actions.size() == 0) begin
            flag_mismatch($sformatf("unexpected result slot %0d action %0d",
                                    rsp_tdata[2:0], rsp_tuser));
         end else begin
            want = expected_actions.pop_front();
            if (rsp_tdata[2:0] != want.slot)
               flag_mismatch($sformatf("slot_out %0d, want %0d", rsp_tdata[2:0], want.slot));
            if (rsp_tuser != want.action)
               flag_mismatch($sformatf("action %0d, want %0d", rsp_tuser, want.action));
            if (rsp_tdata[4:3] != want.mode)
               flag_mismatch($sformatf("mode_after %0d, want %0d", rsp_tdata[4:3], want.mode));
            if (rsp_tlast != want.last)
               flag_mismatch($sformatf("last %0d, want %0d", rsp_tlast, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      while (taken_count != queued_count || expected_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(csr_idx_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ANNOUNCE_COUNT: cfg.announce_count          = value[3:0];
         CSR_PROBE_COUNT:    cfg.probe_count             = value[3:0];
         CSR_PROBE_INTERVAL: cfg.probe_interval          = value;
         CSR_FIRST_ANNOUNCE: cfg.first_announce_interval = value;
         CSR_CONFLICT_DELAY: cfg.conflict_delay          = value;
         default:            cfg.defer_delay             = value;
      endcase
   endtask

   task automatic apply_settings(logic [15:0] ann, logic [15:0] prb, logic [15:0] pint,
                                 logic [15:0] fint, logic [15:0] cdel, logic [15:0] ddel);
      write_setting(CSR_ANNOUNCE_COUNT, ann);
      write_setting(CSR_PROBE_COUNT, prb);
      write_setting(CSR_PROBE_INTERVAL, pint);
      write_setting(CSR_FIRST_ANNOUNCE, fint);
      write_setting(CSR_CONFLICT_DELAY, cdel);
      write_setting(CSR_DEFER_DELAY, ddel);
      @(posedge clock);
      csr_we <= 1'b0;
      // Time steps are scaled to the longest configured interval.
      span = 32'd64;
      if ({16'd0, pint} > span) span = {16'd0, pint};
      if ({16'd0, fint} > span) span = {16'd0, fint};
      if ({16'd0, cdel} > span) span = {16'd0, cdel};
      if ({16'd0, ddel} > span) span = {16'd0, ddel};
   endtask

   // Mostly well-formed traffic: ticks with advancing time, a few flags and table changes.
   task automatic plan_phase(int count, bit with_prefix);
      int r;
      logic [31:0] jump;
      logic [15:0] rnd;
      if (with_prefix) begin
         queue_request(OP_REGISTER, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b1);
         queue_request(OP_REGISTER, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b1);
         queue_request(OP_REGISTER, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b1);
         queue_request(OP_START, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b1);
      end
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            r = $urandom_range(0, 99);
            if (r < 10) jump = 32'd0;
            else if (r < 35) jump = $urandom_range(0, span);
            else if (r < 85) jump = span + $urandom_range(0, span);
            else jump = $urandom_range(span, span * 64);
            clock_ms = clock_ms + jump;
            rnd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            queue_request(OP_TICK, 3'($urandom_range(0, 7)), clock_ms, rnd,
                          $urandom_range(0, 9) != 0);
         end else if (r < 76) begin
            queue_request(OP_CONFLICT, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                          1'b1);
         end else if (r < 79) begin
            queue_request(OP_TIE_LOST, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                          1'b1);
         end else if (r < 83) begin
            queue_request(OP_REGISTER, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                          1'b1);
         end else if (r < 87) begin
            queue_request(OP_UNREGISTER, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                          1'b0);
         end else if (r < 89) begin
            queue_request(OP_RESTART, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                          1'b1);
         end else if (r < 92) begin
            queue_request(OP_START, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b0);
         end else if (r < 93) begin
            queue_request(OP_STOP, 3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b1);
         end else begin
            queue_request(op_type'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
                          16'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings.
      queue_request(OP_TICK, 3'd0, 32'd0, 16'd0, 1'b1);
      queue_request(OP_REGISTER, 3'd0, 32'd0, 16'd0, 1'b0);
      queue_request(OP_REGISTER, 3'd7, 32'd0, 16'd0, 1'b0);
      queue_request(OP_REGISTER, 3'd0, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TICK, 3'd0, 32'd5, 16'd0, 1'b1);
      queue_request(OP_START, 3'd0, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TICK, 3'd0, 32'd10, 16'd0, 1'b0);
      queue_request(OP_TICK, 3'd0, 32'd20, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd20, 16'd0, 1'b1);
      queue_request(OP_CONFLICT, 3'd0, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TIE_LOST, 3'd7, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TICK, 3'd0, 32'd300, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd1300, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd1550, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd1800, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd2050, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd2050, 16'd0, 1'b1);
      queue_request(OP_TICK, 3'd0, 32'd3050, 16'd0, 1'b1);
      queue_request(OP_CONFLICT, 3'd7, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TICK, 3'd0, 32'd3100, 16'd0, 1'b1);
      queue_request(OP_UNREGISTER, 3'd7, 32'd0, 16'd0, 1'b0);
      queue_request(OP_UNREGISTER, 3'd7, 32'd0, 16'd0, 1'b0);
      queue_request(OP_TIE_LOST, 3'd3, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      queue_request(OP_RESTART, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      queue_request(OP_TICK, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      queue_request(OP_STOP, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      wait_idle();

      clock_ms = 32'd4000;
      apply_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
      plan_phase(20, 1'b1);
      wait_idle();

      apply_settings(16'd8, 16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      hold_armed = 1'b1;
      plan_phase(30, 1'b1);
      wait_idle();

      // No prefix here, so slots still announcing meet the lowered count.
      apply_settings(16'd1, 16'd0, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
      plan_phase(16, 1'b0);
      wait_idle();

      // Time runs across the 32-bit wrap.
      clock_ms = 32'hFFFF_0000;
      apply_settings(16'($urandom_range(0, 8)), 16'($urandom_range(1, 8)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      plan_phase(20, 1'b1);
      wait_idle();

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
